[src/yfat_pkg.sv]
// Shared types, widths, constants and tables of the yaw frame alignment transform.
`default_nettype none

package yfat_pkg;

	// Rotation settings
	localparam int CORDIC_STEPS  = 16;
	localparam int FRACTION_BITS = 16;
	localparam int ATAN_COUNT    = 30;

	// Field widths
	localparam int OP_W    = 3;
	localparam int POS_W   = 31;
	localparam int HEAD_W  = 20;
	localparam int OUT_W   = 32;
	localparam int DHEAD_W = 21;

	// Stream widths: fields packed from bit 0 up, padded to whole bytes
	localparam int S_FIELDS_W = 3 * POS_W + HEAD_W;
	localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = 3 * OUT_W + DHEAD_W;
	localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
	localparam int S_USER_W   = OP_W;
	localparam int M_USER_W   = 1;

	// Internal widths
	localparam int DPSI_W = HEAD_W + 1;            // yaw difference / offset
	localparam int PSI_W  = DPSI_W + 1;            // heading plus offset
	localparam int ZSH    = 30 - FRACTION_BITS;    // angle format to Q30
	localparam int Z_W    = DPSI_W + ZSH + 2;      // CORDIC angle accumulator
	localparam int CW     = OUT_W + 3;             // CORDIC x/y datapath
	localparam int SUM_W  = CW + 1;                // sums before saturation
	localparam int MUL_W  = OUT_W;                 // multiplier operand
	localparam int GAIN_W = 31;
	localparam int PROD_W = MUL_W + GAIN_W;
	localparam int ITER_W = $clog2(ATAN_COUNT);

	// Q30 constants
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;
	localparam longint GAIN_Q30    = 64'sd652032874;
	localparam longint TWO_PI_ANG  =
		(TWO_PI_Q30 + (64'sd1 <<< (29 - FRACTION_BITS))) / (64'sd1 <<< (30 - FRACTION_BITS));
	localparam longint HEAD_MIN    = -64'sd1048576;
	localparam longint RND_Q30     = 64'sd1 <<< 29;
	localparam longint SAT_HI      = 64'sd2147483647;
	localparam longint SAT_LO      = -64'sd2147483648;

	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_GUIDE = 3'd0;
	localparam op_t OP_NAV   = 3'd1;
	localparam op_t OP_AP_POS = 3'd2;
	localparam op_t OP_AP_YAW = 3'd3;
	localparam op_t OP_AP_MSG = 3'd4;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [HEAD_W-1:0] head_t;
	typedef logic signed [OUT_W-1:0]  out_t;
	typedef logic signed [DPSI_W-1:0] dpsi_t;
	typedef logic signed [Z_W-1:0]    ang_t;
	typedef logic signed [CW-1:0]     cxy_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	// atan(2^-i) in Q30
	function automatic ang_t atan_q30(input logic [ITER_W-1:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			5'd24: v = 32'h0000003F;
			5'd25: v = 32'h0000001F;
			5'd26: v = 32'h0000000F;
			5'd27: v = 32'h00000008;
			5'd28: v = 32'h00000004;
			5'd29: v = 32'h00000002;
			default: v = 32'h0;
		endcase
		return ang_t'($signed({1'b0, v}));
	endfunction

	// angle in heading format to Q30
	function automatic ang_t ang_to_z(input dpsi_t a);
		ang_t t;
		t = ang_t'(a);
		return t <<< ZSH;
	endfunction

	function automatic out_t sat32(input sum_t v);
		out_t r;
		if (v > sum_t'(SAT_HI))
			r = out_t'(SAT_HI);
		else if (v < sum_t'(SAT_LO))
			r = out_t'(SAT_LO);
		else
			r = out_t'(v);
		return r;
	endfunction

endpackage

`default_nettype wire

[src/yaw_frame_alignment_transform.sv]
// Top level: frame alignment sequencer around a shared CORDIC stage and gain multiplier.
`default_nettype none

// Maps guidance setpoints into the autopilot frame. Beats on the slave side
// carry a tag in s_tuser: guidance setpoint, navigation estimate, autopilot
// position, autopilot yaw or other autopilot message; unknown tags are
// swallowed. Non-guidance beats are latched and give no output.
// Each guidance beat gives exactly one master beat: the held desired pose,
// recomputed (tuser 1) when a fresh navigation estimate and some autopilot
// data are on hand, else stale (tuser 0). The first recompute also fixes the
// yaw and translation offset between the frames, which costs one extra
// rotation. One rotation runs through a single shared CORDIC stage:
// angle reduction, the shared gain multiplier on x and then on y, and
// CORDIC_STEPS micro-rotations, one a cycle. A recomputed guidance beat
// thus runs one rotation, the aligning one two; a stale one skips the
// rotation and goes straight to the output state. The slave side stays
// not ready until the result is loaded into the output register, which
// waits there for m_tready while the next beat is already taken.
// Positions are Q15.16 in, Q16.16 out; angles are radians with FRACTION_BITS
// fraction bits; positions saturate to 32 bits and the output yaw is brought
// to at most two pi.
module yaw_frame_alignment_transform (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// pos_x[30:0], pos_y[61:31], pos_z[92:62], heading[112:93], zero pad
	input  wire logic [yfat_pkg::S_DATA_W-1:0] s_tdata,
	// op[2:0]
	input  wire logic [yfat_pkg::S_USER_W-1:0] s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// des_x[31:0], des_y[63:32], des_z[95:64], des_heading[116:96], zero pad
	output logic [yfat_pkg::M_DATA_W-1:0]      m_tdata,
	// fresh[0]
	output logic [yfat_pkg::M_USER_W-1:0]      m_tuser
);
	import yfat_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_MUL_X,
		ST_MUL_Y,
		ST_MUL_END,
		ST_ITER,
		ST_ALIGN,
		ST_APPLY,
		ST_WRAP,
		ST_OUT
	} state_t;

	localparam ang_t PI_Z      = ang_t'(PI_Q30);
	localparam ang_t HALF_PI_Z = ang_t'(HALF_PI_Q30);
	localparam ang_t TWO_PI_Z  = ang_t'(TWO_PI_Q30);
	localparam logic signed [GAIN_W-1:0] GAIN_S = GAIN_W'(GAIN_Q30);
	localparam logic signed [PROD_W-1:0] RND_P  = PROD_W'(RND_Q30);
	localparam logic signed [PSI_W-1:0]  TWO_PI_PSI = PSI_W'(TWO_PI_ANG);
	localparam logic signed [PSI_W-1:0]  HEAD_MIN_PSI = PSI_W'(HEAD_MIN);
	localparam logic [ITER_W-1:0]        ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

	state_t state_q;

	// Latched poses
	pos_t  nav_x_q, nav_y_q, nav_z_q;
	head_t nav_h_q;
	pos_t  ap_x_q, ap_y_q, ap_z_q;
	head_t ap_h_q;
	pos_t  gd_x_q, gd_y_q, gd_z_q;
	head_t gd_h_q;

	// Frame offset and desired pose
	out_t  off_x_q, off_y_q, off_z_q;
	dpsi_t off_h_q;
	out_t  des_x_q, des_y_q, des_z_q;
	logic signed [DHEAD_W-1:0] des_h_q;

	logic nav_fresh_q, ap_seen_q, need_align_q;
	logic rot_align_q, fresh_pend_q;

	// Rotation datapath
	cxy_t cx_q, cy_q;
	ang_t z_q;
	logic [ITER_W-1:0] iter_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PSI_W-1:0]  psi_q;

	// Slave fields
	op_t   in_op;
	pos_t  in_x, in_y, in_z;
	head_t in_h;
	dpsi_t dpsi;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [PROD_W-1:0] prod_rnd;
	cxy_t scaled;
	cxy_t xs, ys;
	logic accept;

	assign in_op = op_t'(s_tuser);
	assign in_x  = s_tdata[POS_W-1:0];
	assign in_y  = s_tdata[2*POS_W-1:POS_W];
	assign in_z  = s_tdata[3*POS_W-1:2*POS_W];
	assign in_h  = s_tdata[3*POS_W+HEAD_W-1:3*POS_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign dpsi = dpsi_t'(ap_h_q) - dpsi_t'(nav_h_q);

	// shared gain multiplier, rounded half up then floored by 2^30
	assign mul_a    = (state_q == ST_MUL_X) ? cx_q[MUL_W-1:0] : cy_q[MUL_W-1:0];
	assign prod_rnd = prod_q + RND_P;
	assign scaled   = cxy_t'(prod_rnd >>> 30);

	// shared CORDIC shifter
	assign xs = cx_q >>> iter_q;
	assign ys = cy_q >>> iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			nav_x_q      <= '0;
			nav_y_q      <= '0;
			nav_z_q      <= '0;
			nav_h_q      <= '0;
			ap_x_q       <= '0;
			ap_y_q       <= '0;
			ap_z_q       <= '0;
			ap_h_q       <= '0;
			off_x_q      <= '0;
			off_y_q      <= '0;
			off_z_q      <= '0;
			off_h_q      <= '0;
			des_x_q      <= '0;
			des_y_q      <= '0;
			des_z_q      <= '0;
			des_h_q      <= '0;
			nav_fresh_q  <= 1'b0;
			ap_seen_q    <= 1'b0;
			need_align_q <= 1'b1;
			rot_align_q  <= 1'b0;
			fresh_pend_q <= 1'b0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= '0;
		end else begin
			// the output state reloads or holds the beat itself
			if (m_tvalid && m_tready && state_q != ST_OUT)
				m_tvalid <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_op)
							OP_NAV: begin
								nav_x_q     <= in_x;
								nav_y_q     <= in_y;
								nav_z_q     <= in_z;
								nav_h_q     <= in_h;
								nav_fresh_q <= 1'b1;
							end
							OP_AP_POS: begin
								ap_x_q    <= in_x;
								ap_y_q    <= in_y;
								ap_z_q    <= in_z;
								ap_seen_q <= 1'b1;
							end
							OP_AP_YAW: begin
								ap_h_q    <= in_h;
								ap_seen_q <= 1'b1;
							end
							OP_AP_MSG: begin
								ap_seen_q <= 1'b1;
							end
							OP_GUIDE: begin
								gd_x_q <= in_x;
								gd_y_q <= in_y;
								gd_z_q <= in_z;
								gd_h_q <= in_h;
								if (nav_fresh_q && ap_seen_q) begin
									if (need_align_q) begin
										// rotate the navigation position first
										cx_q        <= cxy_t'(nav_x_q);
										cy_q        <= cxy_t'(nav_y_q);
										z_q         <= ang_to_z(dpsi);
										off_h_q     <= dpsi;
										rot_align_q <= 1'b1;
									end else begin
										cx_q        <= cxy_t'(in_x);
										cy_q        <= cxy_t'(in_y);
										z_q         <= ang_to_z(off_h_q);
										rot_align_q <= 1'b0;
									end
									state_q <= ST_NORM;
								end else begin
									fresh_pend_q <= 1'b0;
									state_q      <= ST_OUT;
								end
							end
							default: ;
						endcase
					end
				end

				ST_NORM: begin
					// into (-pi, pi], then a half turn into [-pi/2, pi/2]
					priority if (z_q > PI_Z) begin
						z_q <= z_q - TWO_PI_Z;
					end else if (z_q <= -PI_Z) begin
						z_q <= z_q + TWO_PI_Z;
					end else if (z_q > HALF_PI_Z) begin
						z_q     <= z_q - PI_Z;
						cx_q    <= -cx_q;
						cy_q    <= -cy_q;
						state_q <= ST_MUL_X;
					end else if (z_q < -HALF_PI_Z) begin
						z_q     <= z_q + PI_Z;
						cx_q    <= -cx_q;
						cy_q    <= -cy_q;
						state_q <= ST_MUL_X;
					end else begin
						state_q <= ST_MUL_X;
					end
				end

				ST_MUL_X: begin
					prod_q  <= mul_a * GAIN_S;
					state_q <= ST_MUL_Y;
				end

				ST_MUL_Y: begin
					cx_q    <= scaled;
					prod_q  <= mul_a * GAIN_S;
					state_q <= ST_MUL_END;
				end

				ST_MUL_END: begin
					cy_q    <= scaled;
					iter_q  <= '0;
					state_q <= ST_ITER;
				end

				ST_ITER: begin
					if (z_q >= 0) begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						z_q  <= z_q - atan_q30(iter_q);
					end else begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						z_q  <= z_q + atan_q30(iter_q);
					end
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_LAST)
						state_q <= rot_align_q ? ST_ALIGN : ST_APPLY;
				end

				ST_ALIGN: begin
					off_x_q      <= sat32(sum_t'(ap_x_q) - sum_t'(cx_q));
					off_y_q      <= sat32(sum_t'(ap_y_q) - sum_t'(cy_q));
					off_z_q      <= sat32(sum_t'(ap_z_q) - sum_t'(nav_z_q));
					need_align_q <= 1'b0;
					// now the guidance position with the new offset
					cx_q         <= cxy_t'(gd_x_q);
					cy_q         <= cxy_t'(gd_y_q);
					z_q          <= ang_to_z(off_h_q);
					rot_align_q  <= 1'b0;
					state_q      <= ST_NORM;
				end

				ST_APPLY: begin
					des_x_q     <= sat32(sum_t'(cx_q) + sum_t'(off_x_q));
					des_y_q     <= sat32(sum_t'(cy_q) + sum_t'(off_y_q));
					des_z_q     <= sat32(sum_t'(gd_z_q) + sum_t'(off_z_q));
					psi_q       <= PSI_W'(gd_h_q) + PSI_W'(off_h_q);
					nav_fresh_q <= 1'b0;
					state_q     <= ST_WRAP;
				end

				ST_WRAP: begin
					if (psi_q > TWO_PI_PSI) begin
						psi_q <= psi_q - TWO_PI_PSI;
					end else begin
						des_h_q      <= (psi_q < HEAD_MIN_PSI) ? DHEAD_W'(HEAD_MIN_PSI)
						                                       : DHEAD_W'(psi_q);
						fresh_pend_q <= 1'b1;
						state_q      <= ST_OUT;
					end
				end

				ST_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= M_DATA_W'({des_h_q, des_z_q, des_y_q, des_x_q});
						m_tuser  <= M_USER_W'(fresh_pend_q);
						state_q  <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a result beat only ever comes out of the output state
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT))
		else $error("result beat raised outside the output state");

	// alignment happens once and is never re-armed
	a_align_once: assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(need_align_q))
		else $error("alignment request re-armed");

	// output yaw has been wrapped to at most two pi
	a_yaw_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[3*OUT_W+DHEAD_W-1:3*OUT_W]) <= $signed(DHEAD_W'(TWO_PI_ANG))))
		else $error("desired heading above two pi");

	// a recomputed result has consumed the navigation estimate
	a_fresh_consumes_nav: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(m_tvalid) && m_tuser[0]) |-> !nav_fresh_q)
		else $error("fresh result left navigation marked fresh");
`endif

endmodule

`default_nettype wire
